FILE: rtl/ipf_pkg.sv
// Package for the instruction fetch block: sizes, opcode and status codes,
// word types and opcode decode functions. No dependencies.
package ipf_pkg;

    localparam int MEM_BYTES = 4096;
    localparam int ADDR_W    = $clog2(MEM_BYTES);

    // Instruction codes
    localparam logic [3:0] OP_HALT     = 4'd0;
    localparam logic [3:0] OP_NOP      = 4'd1;
    localparam logic [3:0] OP_RRMOV    = 4'd2;
    localparam logic [3:0] OP_IRMOV    = 4'd3;
    localparam logic [3:0] OP_RMMOV    = 4'd4;
    localparam logic [3:0] OP_MRMOV    = 4'd5;
    localparam logic [3:0] OP_ALU      = 4'd6;
    localparam logic [3:0] OP_JUMP     = 4'd7;
    localparam logic [3:0] OP_CALL     = 4'd8;
    localparam logic [3:0] OP_RET      = 4'd9;
    localparam logic [3:0] OP_PUSH     = 4'd10;
    localparam logic [3:0] OP_POP      = 4'd11;
    localparam logic [3:0] DUMP_OPCODE = 4'd12;
    localparam logic [3:0] NO_REG      = 4'd15;

    // Request operations
    localparam logic OPER_LOAD  = 1'b0;
    localparam logic OPER_FETCH = 1'b1;

    // Status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_HALT = 2'd1;
    localparam logic [1:0] STAT_ADR  = 2'd2;
    localparam logic [1:0] STAT_INS  = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [11:0] load_address;
        logic [7:0]  load_byte;
        logic [3:0]  mem_stage_icode;
        logic        mem_stage_taken;
        logic [31:0] mem_stage_fallthrough;
        logic [3:0]  wb_stage_icode;
        logic [31:0] wb_stage_loaded;
    } ipf_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  icode;
        logic [3:0]  ifun;
        logic [3:0]  reg_a;
        logic [3:0]  reg_b;
        logic [31:0] constant_word;
        logic [31:0] next_sequential;
        logic [31:0] fetch_address;
    } ipf_out_t;

    // Sequencer status toward the top level
    typedef struct packed {
        logic        idle;
        logic        done;
        logic [31:0] pred_next;
    } ipf_stat_t;

    function automatic logic has_reg(input logic [3:0] op);
        return (op == OP_RRMOV) || (op == OP_IRMOV) || (op == OP_RMMOV) ||
               (op == OP_MRMOV) || (op == OP_ALU) || (op == OP_PUSH) ||
               (op == OP_POP);
    endfunction

    function automatic logic has_const(input logic [3:0] op);
        return (op == OP_IRMOV) || (op == OP_RMMOV) || (op == OP_MRMOV) ||
               (op == OP_JUMP) || (op == OP_CALL) || (op == DUMP_OPCODE);
    endfunction

    function automatic logic op_valid(input logic [3:0] op);
        return (op <= OP_POP) || (op == DUMP_OPCODE);
    endfunction

    // Instruction length in bytes: 1, 2, 5 or 6
    function automatic logic [2:0] op_len(input logic [3:0] op);
        logic [2:0] len;
        len = 3'd1;
        if (has_reg(op))
            len = len + 3'd1;
        if (has_const(op))
            len = len + 3'd4;
        return len;
    endfunction

endpackage

FILE: rtl/ipf_if.sv
// Valid/ready channel interfaces for the fetch block request and response.
// Depends on ipf_pkg for the word types.
interface ipf_req_if;
    logic            valid;
    logic            ready;
    ipf_pkg::ipf_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ipf_rsp_if;
    logic             valid;
    logic             ready;
    ipf_pkg::ipf_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/pipelined_instruction_fetch_top.sv
// Y86 fetch stage top level. Load word: no response.
// Fetch word: the response is built from the byte-wide memory read one byte
// per cycle; the next request is taken once the fetched word has moved to the
// response register, and loads are taken one per cycle while idle.
// One word in flight; the response register lets the next request
// be accepted while a response waits. Reset clears the predicted PC to zero;
// the instruction memory is not cleared and holds garbage until loaded.
module pipelined_instruction_fetch_top
(
    input  logic clk,
    input  logic rst_n,
    ipf_req_if.sink   req,
    ipf_rsp_if.source rsp
);

    logic                       accept;
    logic                       start;
    logic [31:0]                sel_pc;
    logic [31:0]                load_addr32;
    logic                       wr_en;
    logic                       rd_en;
    logic [ipf_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                 rd_data;
    logic                       ack;
    ipf_pkg::ipf_out_t          res;
    ipf_pkg::ipf_stat_t         stat;

    logic [31:0]       pred_pc_reg, pred_pc_next;
    logic              out_valid_reg, out_valid_next;
    ipf_pkg::ipf_out_t out_data_reg, out_data_next;

    assign req.ready = stat.idle;
    assign accept    = req.valid && req.ready;
    assign start     = accept && (req.data.operation == ipf_pkg::OPER_FETCH);

    // PC select: mispredicted jump, then return, then prediction
    always_comb
    begin
        if ((req.data.mem_stage_icode == ipf_pkg::OP_JUMP) && !req.data.mem_stage_taken)
            sel_pc = req.data.mem_stage_fallthrough;
        else if (req.data.wb_stage_icode == ipf_pkg::OP_RET)
            sel_pc = req.data.wb_stage_loaded;
        else
            sel_pc = pred_pc_reg;
    end

    // load path, out-of-range addresses dropped
    assign load_addr32 = {20'd0, req.data.load_address};
    assign wr_en = accept && (req.data.operation == ipf_pkg::OPER_LOAD) &&
                   (load_addr32 < 32'(ipf_pkg::MEM_BYTES));

    ipf_imem u_imem
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (load_addr32[ipf_pkg::ADDR_W-1:0]),
        .wr_data (req.data.load_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ipf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .start_pc (sel_pc),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .ack      (ack),
        .res      (res),
        .stat     (stat)
    );

    // response register and prediction update
    assign ack = stat.done && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        pred_pc_next   = pred_pc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (rsp.ready)
            out_valid_next = 1'b0;
        if (ack)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
            pred_pc_next   = stat.pred_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_pc_reg   <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pred_pc_reg   <= pred_pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule

FILE: rtl/ipf_imem.sv
// Byte-wide instruction memory: one write port, one read port, registered read.
// Depends on ipf_pkg for the depth.
module ipf_imem
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ipf_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                 wr_data,
    input  logic                       rd_en,
    input  logic [ipf_pkg::ADDR_W-1:0] rd_addr,
    output logic [7:0]                 rd_data
);

    logic [7:0] mem [ipf_pkg::MEM_BYTES];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/ipf_ctrl.sv
// Fetch sequencer: walks the instruction bytes one a cycle through a shared
// address incrementer and range compare, and assembles the decoded word.
// Depends on ipf_pkg.
module ipf_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [31:0]                start_pc,
    output logic                       rd_en,
    output logic [ipf_pkg::ADDR_W-1:0] rd_addr,
    input  logic [7:0]                 rd_data,
    input  logic                       ack,
    output ipf_pkg::ipf_out_t          res,
    output ipf_pkg::ipf_stat_t         stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [2:0]  issue_idx_reg, issue_idx_next;
    logic        rx_valid_reg, rx_valid_next;
    logic        rx_bad_reg, rx_bad_next;
    logic [2:0]  rx_idx_reg, rx_idx_next;

    logic [31:0] pc_reg, pc_next;
    logic [31:0] addr_reg, addr_next;
    logic [3:0]  icode_reg, icode_next;
    logic [3:0]  ifun_reg, ifun_next;
    logic [3:0]  ra_reg, ra_next;
    logic [3:0]  rb_reg, rb_next;
    logic [31:0] valc_reg, valc_next;
    logic        bad_reg, bad_next;
    logic [2:0]  len_reg, len_next;

    logic        addr_bad;
    logic        proc;
    logic [2:0]  cur_len;
    logic [2:0]  cbase;
    logic [2:0]  koff;
    logic [31:0] valc_fin;
    logic [31:0] next_seq;

    // shared range compare on the address being issued
    assign addr_bad = (addr_reg >= 32'(ipf_pkg::MEM_BYTES));
    assign rd_en    = (state_reg == S_RUN) && !addr_bad;
    assign rd_addr  = addr_reg[ipf_pkg::ADDR_W-1:0];

    // a byte from the memory is being interpreted this cycle
    assign proc  = (state_reg == S_RUN) && rx_valid_reg;
    assign cbase = ipf_pkg::has_reg(icode_reg) ? 3'd2 : 3'd1;
    assign koff  = rx_idx_reg - cbase;

    always_comb
    begin
        state_next     = state_reg;
        issue_idx_next = issue_idx_reg;
        rx_valid_next  = 1'b0;
        rx_bad_next    = rx_bad_reg;
        rx_idx_next    = rx_idx_reg;
        pc_next        = pc_reg;
        addr_next      = addr_reg;
        icode_next     = icode_reg;
        ifun_next      = ifun_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        valc_next      = valc_reg;
        bad_next       = bad_reg;
        len_next       = len_reg;
        cur_len        = len_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next     = S_RUN;
                    pc_next        = start_pc;
                    addr_next      = start_pc;
                    issue_idx_next = 3'd0;
                    ra_next        = ipf_pkg::NO_REG;
                    rb_next        = ipf_pkg::NO_REG;
                    valc_next      = 32'd0;
                    bad_next       = 1'b0;
                end
            end
            S_RUN:
            begin
                // issue the next sequential byte
                addr_next      = addr_reg + 32'd1;
                issue_idx_next = issue_idx_reg + 3'd1;
                rx_valid_next  = 1'b1;
                rx_bad_next    = addr_bad;
                rx_idx_next    = issue_idx_reg;

                if (proc)
                begin
                    bad_next = bad_reg | rx_bad_reg;
                    if (rx_idx_reg == 3'd0)
                    begin
                        // opcode byte
                        if (rx_bad_reg)
                        begin
                            icode_next = ipf_pkg::OP_NOP;
                            ifun_next  = 4'd0;
                            cur_len    = 3'd1;
                        end
                        else
                        begin
                            icode_next = rd_data[7:4];
                            ifun_next  = rd_data[3:0];
                            cur_len    = ipf_pkg::op_len(rd_data[7:4]);
                        end
                        len_next = cur_len;
                    end
                    else if (ipf_pkg::has_reg(icode_reg) && (rx_idx_reg == 3'd1))
                    begin
                        // register byte
                        if (!rx_bad_reg && !bad_reg)
                        begin
                            ra_next = rd_data[7:4];
                            rb_next = rd_data[3:0];
                        end
                    end
                    else
                    begin
                        // constant bytes, little endian
                        if (!rx_bad_reg && !bad_reg)
                        begin
                            case (koff[1:0])
                                2'd0:    valc_next[7:0]   = rd_data;
                                2'd1:    valc_next[15:8]  = rd_data;
                                2'd2:    valc_next[23:16] = rd_data;
                                default: valc_next[31:24] = rd_data;
                            endcase
                        end
                    end

                    if (rx_idx_reg == (cur_len - 3'd1))
                        state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (ack)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result assembly
    assign valc_fin = bad_reg ? 32'd0 : valc_reg;
    assign next_seq = pc_reg + {29'd0, len_reg};

    always_comb
    begin
        res.icode           = icode_reg;
        res.ifun            = ifun_reg;
        res.reg_a           = ra_reg;
        res.reg_b           = rb_reg;
        res.constant_word   = valc_fin;
        res.next_sequential = next_seq;
        res.fetch_address   = pc_reg;
        if (bad_reg)
            res.status = ipf_pkg::STAT_ADR;
        else if (!ipf_pkg::op_valid(icode_reg))
            res.status = ipf_pkg::STAT_INS;
        else if (icode_reg == ipf_pkg::OP_HALT)
            res.status = ipf_pkg::STAT_HALT;
        else
            res.status = ipf_pkg::STAT_OK;
    end

    assign stat.idle      = (state_reg == S_IDLE);
    assign stat.done      = (state_reg == S_DONE);
    assign stat.pred_next = ((icode_reg == ipf_pkg::OP_JUMP) ||
                             (icode_reg == ipf_pkg::OP_CALL)) ? valc_fin : next_seq;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_idx_reg <= 3'd0;
            rx_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_idx_reg <= issue_idx_next;
            rx_valid_reg  <= rx_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rx_bad_reg <= rx_bad_next;
        rx_idx_reg <= rx_idx_next;
        pc_reg     <= pc_next;
        addr_reg   <= addr_next;
        icode_reg  <= icode_next;
        ifun_reg   <= ifun_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        valc_reg   <= valc_next;
        bad_reg    <= bad_next;
        len_reg    <= len_next;
    end

endmodule

FILE: tb/pipelined_instruction_fetch_top_tb.sv
`timescale 1ns / 100ps
// Testbench for the Y86 fetch stage: a queued driver and a checking monitor
// on the request and response channels. Depends on ipf_pkg and ipf_if.sv.
module pipelined_instruction_fetch_top_tb;

    import ipf_pkg::*;

    localparam int unsigned TOTAL_WORDS = 550;
    localparam int unsigned CALM_WORDS  = 60;   // no idling for the last words
    localparam int unsigned HOLD_AFTER  = 150;
    localparam int unsigned HOLD_CYCLES = 120;
    localparam int unsigned DRAIN_CYCLES = 16;

    typedef struct {
        ipf_in_t  word;
        bit       makes_rsp;
        ipf_out_t rsp;
    } pending_word_t;

    logic clk;
    logic rst_n;

    ipf_req_if req_bus ();
    ipf_rsp_if rsp_bus ();

    pipelined_instruction_fetch_top i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Shadow of the fetch stage state
    logic [7:0]  imem [MEM_BYTES];
    bit          loaded_map [MEM_BYTES];
    logic [31:0] pred_pc;

    // Stimulus and scoreboard storage
    pending_word_t word_q[$];
    ipf_out_t      fetch_expect_q[$];
    logic [31:0]   insn_starts[$];
    int unsigned   prog_at;

    int unsigned words_accepted;
    int unsigned mismatches;
    int unsigned gap_left;
    int unsigned stall_left;
    bit          calm;
    bit          hold_rsp;

    // Which extra bytes an opcode carries
    function automatic void insn_shape(input logic [3:0] op, output bit with_reg,
                                       output bit with_const);
        case (op)
            OP_RRMOV, OP_ALU, OP_PUSH, OP_POP:
            begin
                with_reg   = 1'b1;
                with_const = 1'b0;
            end
            OP_IRMOV, OP_RMMOV, OP_MRMOV:
            begin
                with_reg   = 1'b1;
                with_const = 1'b1;
            end
            OP_JUMP, OP_CALL, DUMP_OPCODE:
            begin
                with_reg   = 1'b0;
                with_const = 1'b1;
            end
            default:
            begin
                with_reg   = 1'b0;
                with_const = 1'b0;
            end
        endcase
    endfunction

    // One memory byte; flags out-of-range and never-loaded reads
    function automatic logic [7:0] fetch_byte(input logic [31:0] a, inout bit adr_err,
                                              inout bit clean);
        if (a >= 32'(MEM_BYTES))
        begin
            adr_err = 1'b1;
            return 8'h00;
        end
        if (!loaded_map[a[ADDR_W-1:0]])
            clean = 1'b0;
        return imem[a[ADDR_W-1:0]];
    endfunction

    // Decode at pc; clean is low if any byte read was never loaded
    function automatic ipf_out_t predict_fetch(input logic [31:0] pc, output bit clean,
                                               output logic [31:0] next_pc);
        ipf_out_t    r;
        logic [7:0]  b;
        logic [31:0] k;
        bit          adr_err;
        bit          with_reg;
        bit          with_const;
        int unsigned n;
        adr_err = 1'b0;
        clean   = 1'b1;
        r.reg_a = NO_REG;
        r.reg_b = NO_REG;
        r.constant_word = '0;
        b = fetch_byte(pc, adr_err, clean);
        r.icode = adr_err ? OP_NOP : b[7:4];
        r.ifun  = adr_err ? 4'h0 : b[3:0];
        insn_shape(r.icode, with_reg, with_const);
        n = 1;
        if (with_reg)
        begin
            if (!adr_err)
            begin
                b = fetch_byte(pc + 32'd1, adr_err, clean);
                if (!adr_err)
                begin
                    r.reg_a = b[7:4];
                    r.reg_b = b[3:0];
                end
            end
            n = 2;
        end
        if (with_const)
        begin
            if (!adr_err)
            begin
                k = '0;
                for (int unsigned i = 0; i < 4; i++)
                    k[8*i +: 8] = fetch_byte(pc + n + i, adr_err, clean);
                r.constant_word = adr_err ? 32'h0 : k;
            end
            n = n + 4;
        end
        // bad address wins over bad instruction, which wins over halt
        if (adr_err)
            r.status = STAT_ADR;
        else if (r.icode > OP_POP && r.icode != DUMP_OPCODE)
            r.status = STAT_INS;
        else if (r.icode == OP_HALT)
            r.status = STAT_HALT;
        else
            r.status = STAT_OK;
        r.next_sequential = pc + n;
        r.fetch_address   = pc;
        if (r.icode == OP_JUMP || r.icode == OP_CALL)
            next_pc = r.constant_word;
        else
            next_pc = pc + n;
        return r;
    endfunction

    // Mispredicted jump first, then return, then the predicted PC
    function automatic logic [31:0] select_pc(input ipf_in_t w);
        if (w.mem_stage_icode == OP_JUMP && !w.mem_stage_taken)
            return w.mem_stage_fallthrough;
        if (w.wb_stage_icode == OP_RET)
            return w.wb_stage_loaded;
        return pred_pc;
    endfunction

    function automatic ipf_in_t random_word();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(ipf_in_t)-1:0];
    endfunction

    function automatic void queue_load(input logic [11:0] a, input logic [7:0] d);
        pending_word_t p;
        p.word = random_word();
        p.word.operation    = OPER_LOAD;
        p.word.load_address = a;
        p.word.load_byte    = d;
        p.makes_rsp = 1'b0;
        p.rsp       = '0;
        imem[a]       = d;
        loaded_map[a] = 1'b1;
        word_q.push_back(p);
    endfunction

    // Queue a fetch; steer it through a mispredict when it would touch
    // bytes that were never loaded
    function automatic void queue_fetch(input ipf_in_t w);
        pending_word_t p;
        bit            clean;
        logic [31:0]   nxt;
        int unsigned   tries;
        w.operation = OPER_FETCH;
        p.rsp = predict_fetch(select_pc(w), clean, nxt);
        tries = 0;
        while (!clean)
        begin
            w.mem_stage_icode = OP_JUMP;
            w.mem_stage_taken = 1'b0;
            if (tries < 8 && insn_starts.size() != 0)
                w.mem_stage_fallthrough = insn_starts[$urandom_range(0, insn_starts.size() - 1)];
            else
            begin
                w.mem_stage_fallthrough = $urandom;
                if (w.mem_stage_fallthrough < 32'(MEM_BYTES))
                    w.mem_stage_fallthrough += 32'(MEM_BYTES);
            end
            tries++;
            p.rsp = predict_fetch(select_pc(w), clean, nxt);
        end
        pred_pc     = nxt;
        p.word      = w;
        p.makes_rsp = 1'b1;
        word_q.push_back(p);
    endfunction

    function automatic ipf_in_t fetch_word(input logic [3:0] mi, input logic mt,
                                           input logic [31:0] mf, input logic [3:0] wi,
                                           input logic [31:0] wl);
        ipf_in_t w;
        w = random_word();
        w.mem_stage_icode       = mi;
        w.mem_stage_taken       = mt;
        w.mem_stage_fallthrough = mf;
        w.wb_stage_icode        = wi;
        w.wb_stage_loaded       = wl;
        return w;
    endfunction

    // Lay one instruction down at the program cursor
    function automatic void write_insn(input logic [3:0] op, input logic [3:0] fn,
                                       input logic [7:0] regs, input logic [31:0] k);
        bit          with_reg;
        bit          with_const;
        int unsigned at;
        insn_shape(op, with_reg, with_const);
        if (prog_at > MEM_BYTES - 6)
            prog_at = $urandom_range(0, MEM_BYTES - 7);
        at = prog_at;
        insn_starts.push_back(at);
        queue_load(12'(at), {op, fn});
        at++;
        if (with_reg)
        begin
            queue_load(12'(at), regs);
            at++;
        end
        if (with_const)
        begin
            for (int i = 0; i < 4; i++)
            begin
                queue_load(12'(at), k[8*i +: 8]);
                at++;
            end
        end
        prog_at = at;
    endfunction

    function automatic void build_stimulus();
        int unsigned r;
        logic [3:0]  op;
        logic [31:0] k;
        ipf_in_t     w;
        pred_pc = '0;
        // Directed: edges of memory, PC source priority, status codes
        queue_load(12'h000, {OP_NOP, 4'h0});
        queue_fetch(fetch_word(OP_NOP, 1'b0, 32'h0, OP_NOP, 32'h0));
        queue_load(12'hFFF, {OP_RRMOV, 4'h0});
        // register byte falls off the end of memory
        queue_fetch(fetch_word(OP_JUMP, 1'b0, 32'h0000_0FFF, OP_NOP, 32'h0));
        // opcode address out of range
        queue_fetch(fetch_word(OP_NOP, 1'b0, 32'h0, OP_NOP, 32'h0));
        // return to the top address, sequential PC wraps to zero
        queue_fetch(fetch_word(OP_NOP, 1'b0, 32'h0, OP_RET, 32'hFFFF_FFFF));
        queue_load(12'hFFC, {OP_JUMP, 4'h0});
        queue_load(12'hFFD, 8'h11);
        queue_load(12'hFFE, 8'h22);
        // jump constant straddles the end of memory
        queue_fetch(fetch_word(OP_JUMP, 1'b0, 32'h0000_0FFC, OP_NOP, 32'h0));
        queue_load(12'h001, 8'hF5);
        queue_fetch(fetch_word(OP_NOP, 1'b0, 32'h0, OP_NOP, 32'h0));
        queue_fetch(fetch_word(OP_NOP, 1'b0, 32'h0, OP_NOP, 32'h0));
        queue_load(12'h002, {OP_HALT, 4'h0});
        queue_fetch(fetch_word(OP_NOP, 1'b0, 32'h0, OP_NOP, 32'h0));
        queue_load(12'h003, {DUMP_OPCODE, 4'h0});
        for (int i = 4; i < 8; i++)
            queue_load(12'(i), 8'hFF);
        // taken jump in the memory stage does not redirect
        queue_fetch(fetch_word(OP_JUMP, 1'b1, 32'hFFFF_FFFF, OP_NOP, 32'h0));
        // mispredict beats return
        queue_fetch(fetch_word(OP_JUMP, 1'b0, 32'h0, OP_RET, 32'h2));
        queue_fetch(fetch_word(OP_JUMP, 1'b1, 32'h0, OP_RET, 32'h2));
        insn_starts = '{32'h0, 32'h1, 32'h2, 32'h3};
        prog_at = $urandom_range(16, MEM_BYTES - 7);

        // Random: mostly programs walked along the predicted path
        while (word_q.size() < TOTAL_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
            begin
                op = 4'($urandom);
                k  = $urandom;
                if ((op == OP_JUMP || op == OP_CALL) && $urandom_range(0, 2) != 0)
                    k = insn_starts[$urandom_range(0, insn_starts.size() - 1)];
                if ($urandom_range(0, 9) == 0)
                    prog_at = $urandom_range(0, MEM_BYTES - 1);
                write_insn(op, 4'($urandom), 8'($urandom), k);
            end
            else if (r < 30)
                queue_load(12'($urandom), 8'($urandom));
            else
            begin
                w = random_word();
                if ($urandom_range(0, 7) == 0)
                begin
                    w.wb_stage_icode  = OP_RET;
                    w.wb_stage_loaded = insn_starts[$urandom_range(0, insn_starts.size() - 1)];
                end
                queue_fetch(w);
            end
        end
    endfunction

    task automatic check_result(input ipf_out_t want, input ipf_out_t got);
        if (got.status !== want.status || got.icode !== want.icode ||
            got.ifun !== want.ifun || got.reg_a !== want.reg_a ||
            got.reg_b !== want.reg_b || got.constant_word !== want.constant_word ||
            got.next_sequential !== want.next_sequential ||
            got.fetch_address !== want.fetch_address)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("mismatch want: st %0d ic %h fn %h ra %h rb %h valc %h valp %h pc %h",
                         want.status, want.icode, want.ifun, want.reg_a, want.reg_b,
                         want.constant_word, want.next_sequential, want.fetch_address);
                $display("         got:  st %0d ic %h fn %h ra %h rb %h valc %h valp %h pc %h",
                         got.status, got.icode, got.ifun, got.reg_a, got.reg_b,
                         got.constant_word, got.next_sequential, got.fetch_address);
            end
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Request driver: presents the head of the queue, random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
            req_bus.data  <= '0;
            calm          <= 1'b0;
            gap_left      = 0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                if (word_q[0].makes_rsp)
                    fetch_expect_q.push_back(word_q[0].rsp);
                void'(word_q.pop_front());
                words_accepted++;
                if (gap_left != 0)
                begin
                    gap_left--;
                    req_bus.valid <= 1'b0;
                end
                else if (word_q.size() == 0)
                    req_bus.valid <= 1'b0;
                else if (!calm && $urandom_range(0, 4) == 0)
                begin
                    gap_left = $urandom_range(0, 2);
                    req_bus.valid <= 1'b0;
                end
                else
                begin
                    req_bus.valid <= 1'b1;
                    req_bus.data  <= word_q[0].word;
                end
            end
            else if (!req_bus.valid)
            begin
                if (gap_left != 0)
                    gap_left--;
                else if (word_q.size() != 0 && (calm || $urandom_range(0, 4) != 0))
                begin
                    req_bus.valid <= 1'b1;
                    req_bus.data  <= word_q[0].word;
                end
                else if (word_q.size() != 0)
                    gap_left = $urandom_range(0, 2);
            end
            calm <= (word_q.size() < CALM_WORDS);
        end
    end

    // Response monitor: checks each word, random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            stall_left    = 0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (fetch_expect_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response word, pc %h",
                                 rsp_bus.data.fetch_address);
                end
                else
                    check_result(fetch_expect_q.pop_front(), rsp_bus.data);
            end
            if (hold_rsp)
                rsp_bus.ready <= 1'b0;
            else if (stall_left != 0)
            begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                rsp_bus.ready <= 1'b0;
            end
            else
                rsp_bus.ready <= 1'b1;
        end
    end

    // Long receiver hold-off so the block backs up into its input
    initial
    begin
        hold_rsp = 1'b0;
        wait (words_accepted >= HOLD_AFTER);
        @(posedge clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp <= 1'b0;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("[pipelined_instruction_fetch_top] ERROR");
        $finish;
    end

    // Reset, stimulus, end of run
    initial
    begin
        rst_n          = 1'b0;
        req_bus.valid  = 1'b0;
        req_bus.data   = '0;
        rsp_bus.ready  = 1'b0;
        words_accepted = 0;
        mismatches     = 0;
        build_stimulus();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        while (word_q.size() != 0 || fetch_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[pipelined_instruction_fetch_top] OK");
        else
            $display("[pipelined_instruction_fetch_top] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ipf_pkg.sv
rtl/ipf_if.sv
rtl/ipf_imem.sv
rtl/ipf_ctrl.sv
rtl/pipelined_instruction_fetch_top.sv
tb/pipelined_instruction_fetch_top_tb.sv
